// ----- rtl/core/rim_pkg.sv -----
// ----------------------------------------------------------------------------
// rim_pkg: shared types and arithmetic for the information matrix block
// Sum types, overflow mark positions, saturating adders and entry mapping.
// ----------------------------------------------------------------------------
package rim_pkg;

  localparam int MAX_POINTS_DEF = 65536;
  localparam int COORD_W        = 24;
  localparam int PROD_W         = 2 * COORD_W;
  localparam int LIN_W          = 41;
  localparam int ACC_W          = 64;
  localparam int FRAC_OUT       = 24;   // fraction bits of an entry
  localparam int LIN_SHIFT      = 12;   // Q.12 linear sums scaled up to Q.24
  localparam int IN_DATA_W      = 3 * COORD_W;
  localparam int OUT_DATA_W     = 72;   // row, col, value, padded to bytes
  localparam int MARK_N         = 9;

  // Sticky overflow mark positions
  localparam int OVM_XX = 0;
  localparam int OVM_YY = 1;
  localparam int OVM_ZZ = 2;
  localparam int OVM_XY = 3;
  localparam int OVM_XZ = 4;
  localparam int OVM_YZ = 5;
  localparam int OVM_SX = 6;
  localparam int OVM_SY = 7;
  localparam int OVM_SZ = 8;

  localparam logic [2:0] LAST_IDX = 3'd5;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [LIN_W-1:0] LIN_MAX = {1'b0, {(LIN_W-1){1'b1}}};
  localparam logic signed [LIN_W-1:0] LIN_MIN = {1'b1, {(LIN_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ACC_W-1:0] sxx;
    logic signed [ACC_W-1:0] syy;
    logic signed [ACC_W-1:0] szz;
    logic signed [ACC_W-1:0] sxy;
    logic signed [ACC_W-1:0] sxz;
    logic signed [ACC_W-1:0] syz;
    logic signed [LIN_W-1:0] sx;
    logic signed [LIN_W-1:0] sy;
    logic signed [LIN_W-1:0] sz;
  } sums_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] v;
    logic                    ov;
  } sat64_t;

  typedef struct packed {
    logic signed [LIN_W-1:0] v;
    logic                    ov;
  } lin_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic                    sat;
  } entry_t;

  function automatic sat64_t sat_add(logic signed [ACC_W-1:0] a,
                                     logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] r;
    sat64_t                  o;
    r    = a + b;
    o.ov = (a[ACC_W-1] == b[ACC_W-1]) && (r[ACC_W-1] != a[ACC_W-1]);
    o.v  = o.ov ? (a[ACC_W-1] ? ACC_MIN : ACC_MAX) : r;
    return o;
  endfunction

  function automatic sat64_t sat_neg(logic signed [ACC_W-1:0] a);
    sat64_t o;
    o.ov = (a == ACC_MIN);
    o.v  = o.ov ? ACC_MAX : -a;
    return o;
  endfunction

  function automatic lin_t lin_add(logic signed [LIN_W-1:0]   s,
                                   logic signed [COORD_W-1:0] c);
    logic signed [LIN_W:0] r;
    lin_t                  o;
    r    = {s[LIN_W-1], s} + {{(LIN_W+1-COORD_W){c[COORD_W-1]}}, c};
    o.ov = (r[LIN_W] != r[LIN_W-1]);
    o.v  = o.ov ? (r[LIN_W] ? LIN_MIN : LIN_MAX) : r[LIN_W-1:0];
    return o;
  endfunction

  // Linear sum in Q.12 widened to a Q.24 entry
  function automatic logic signed [ACC_W-1:0] lin_scale(logic signed [LIN_W-1:0] s);
    return {{(ACC_W-LIN_W-LIN_SHIFT){s[LIN_W-1]}}, s, {LIN_SHIFT{1'b0}}};
  endfunction

  // One matrix entry; the matrix is symmetric so only the upper half is decoded
  function automatic entry_t calc_entry(sums_t s, logic [MARK_N-1:0] m,
                                        logic signed [ACC_W-1:0] cnt,
                                        logic [2:0] row, logic [2:0] col);
    logic [2:0] a;
    logic [2:0] b;
    sat64_t     t;
    entry_t     e;
    a       = (row < col) ? row : col;
    b       = (row < col) ? col : row;
    e.value = '0;
    e.sat   = 1'b0;
    t       = '0;
    unique case ({a, b})
      {3'd0, 3'd0}: begin
        t = sat_add(s.syy, s.szz);
        e.value = t.v;
        e.sat = m[OVM_YY] | m[OVM_ZZ] | t.ov;
      end
      {3'd1, 3'd1}: begin
        t = sat_add(s.sxx, s.szz);
        e.value = t.v;
        e.sat = m[OVM_XX] | m[OVM_ZZ] | t.ov;
      end
      {3'd2, 3'd2}: begin
        t = sat_add(s.sxx, s.syy);
        e.value = t.v;
        e.sat = m[OVM_XX] | m[OVM_YY] | t.ov;
      end
      {3'd0, 3'd1}: begin
        t = sat_neg(s.sxy);
        e.value = t.v;
        e.sat = m[OVM_XY] | t.ov;
      end
      {3'd0, 3'd2}: begin
        t = sat_neg(s.sxz);
        e.value = t.v;
        e.sat = m[OVM_XZ] | t.ov;
      end
      {3'd1, 3'd2}: begin
        t = sat_neg(s.syz);
        e.value = t.v;
        e.sat = m[OVM_YZ] | t.ov;
      end
      {3'd0, 3'd4}: begin
        e.value = -lin_scale(s.sz);
        e.sat = m[OVM_SZ];
      end
      {3'd0, 3'd5}: begin
        e.value = lin_scale(s.sy);
        e.sat = m[OVM_SY];
      end
      {3'd1, 3'd3}: begin
        e.value = lin_scale(s.sz);
        e.sat = m[OVM_SZ];
      end
      {3'd1, 3'd5}: begin
        e.value = -lin_scale(s.sx);
        e.sat = m[OVM_SX];
      end
      {3'd2, 3'd3}: begin
        e.value = -lin_scale(s.sy);
        e.sat = m[OVM_SY];
      end
      {3'd2, 3'd4}: begin
        e.value = lin_scale(s.sx);
        e.sat = m[OVM_SX];
      end
      {3'd3, 3'd3}, {3'd4, 3'd4}, {3'd5, 3'd5}: begin
        e.value = cnt;
      end
      default: begin
        e.value = '0;
      end
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/core/rim_accum.sv -----
// ----------------------------------------------------------------------------
// rim_accum: point accumulator
// Input register, product stage and saturating running sums. Hands a
// snapshot of the sums to the emitter on the point marked last.
// ----------------------------------------------------------------------------
module rim_accum #(
  parameter int MAX_POINTS = rim_pkg::MAX_POINTS_DEF,
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [rim_pkg::COORD_W-1:0]   x_i,
  input  logic signed [rim_pkg::COORD_W-1:0]   y_i,
  input  logic signed [rim_pkg::COORD_W-1:0]   z_i,
  input  logic                                 last_i,
  input  logic                                 emit_busy_i,
  output logic                                 snap_load_o,
  output rim_pkg::sums_t                       snap_o,
  output logic [rim_pkg::MARK_N-1:0]           snap_marks_o,
  output logic [CNT_W-1:0]                     snap_cnt_o
);
  import rim_pkg::*;

  logic adv;

  // input stage
  logic                      a_valid_q;
  logic                      a_last_q;
  logic signed [COORD_W-1:0] a_x_q, a_y_q, a_z_q;

  // product stage
  logic                      b_valid_q;
  logic                      b_last_q;
  logic signed [COORD_W-1:0] b_x_q, b_y_q, b_z_q;
  logic signed [PROD_W-1:0]  pxx_d, pyy_d, pzz_d, pxy_d, pxz_d, pyz_d;
  logic signed [PROD_W-1:0]  pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q;

  // running sums
  sums_t             sums_q, sums_d;
  logic [MARK_N-1:0] marks_q, marks_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              take;
  logic              acc_en;
  sat64_t            r_xx, r_yy, r_zz, r_xy, r_xz, r_yz;
  lin_t              r_x, r_y, r_z;

  // Everything moves together; only a second set end that finds the emitter
  // still draining holds the pipe.
  assign adv        = !(b_valid_q && b_last_q && emit_busy_i);
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  assign pxx_d = a_x_q * a_x_q;
  assign pyy_d = a_y_q * a_y_q;
  assign pzz_d = a_z_q * a_z_q;
  assign pxy_d = a_x_q * a_y_q;
  assign pxz_d = a_x_q * a_z_q;
  assign pyz_d = a_y_q * a_z_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_x_q    <= x_i;
      a_y_q    <= y_i;
      a_z_q    <= z_i;
      a_last_q <= last_i;
      b_x_q    <= a_x_q;
      b_y_q    <= a_y_q;
      b_z_q    <= a_z_q;
      b_last_q <= a_last_q;
      pxx_q    <= pxx_d;
      pyy_q    <= pyy_d;
      pzz_q    <= pzz_d;
      pxy_q    <= pxy_d;
      pxz_q    <= pxz_d;
      pyz_q    <= pyz_d;
    end
  end

  assign take   = adv && b_valid_q;
  assign acc_en = take && (cnt_q < CNT_W'(MAX_POINTS));

  always_comb begin
    r_xx = sat_add(sums_q.sxx, ACC_W'(pxx_q));
    r_yy = sat_add(sums_q.syy, ACC_W'(pyy_q));
    r_zz = sat_add(sums_q.szz, ACC_W'(pzz_q));
    r_xy = sat_add(sums_q.sxy, ACC_W'(pxy_q));
    r_xz = sat_add(sums_q.sxz, ACC_W'(pxz_q));
    r_yz = sat_add(sums_q.syz, ACC_W'(pyz_q));
    r_x  = lin_add(sums_q.sx, b_x_q);
    r_y  = lin_add(sums_q.sy, b_y_q);
    r_z  = lin_add(sums_q.sz, b_z_q);
    sums_d  = sums_q;
    marks_d = marks_q;
    cnt_d   = cnt_q;
    if (acc_en) begin
      sums_d.sxx = r_xx.v;
      sums_d.syy = r_yy.v;
      sums_d.szz = r_zz.v;
      sums_d.sxy = r_xy.v;
      sums_d.sxz = r_xz.v;
      sums_d.syz = r_yz.v;
      sums_d.sx  = r_x.v;
      sums_d.sy  = r_y.v;
      sums_d.sz  = r_z.v;
      marks_d[OVM_XX] = marks_q[OVM_XX] | r_xx.ov;
      marks_d[OVM_YY] = marks_q[OVM_YY] | r_yy.ov;
      marks_d[OVM_ZZ] = marks_q[OVM_ZZ] | r_zz.ov;
      marks_d[OVM_XY] = marks_q[OVM_XY] | r_xy.ov;
      marks_d[OVM_XZ] = marks_q[OVM_XZ] | r_xz.ov;
      marks_d[OVM_YZ] = marks_q[OVM_YZ] | r_yz.ov;
      marks_d[OVM_SX] = marks_q[OVM_SX] | r_x.ov;
      marks_d[OVM_SY] = marks_q[OVM_SY] | r_y.ov;
      marks_d[OVM_SZ] = marks_q[OVM_SZ] | r_z.ov;
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  // The last point is folded in first, then the sums restart from zero.
  assign snap_load_o  = take && b_last_q;
  assign snap_o       = sums_d;
  assign snap_marks_o = marks_d;
  assign snap_cnt_o   = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q  <= '0;
      marks_q <= '0;
      cnt_q   <= '0;
    end else if (snap_load_o) begin
      sums_q  <= '0;
      marks_q <= '0;
      cnt_q   <= '0;
    end else begin
      sums_q  <= sums_d;
      marks_q <= marks_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/rim_emit.sv -----
// ----------------------------------------------------------------------------
// rim_emit: matrix emitter
// Holds one snapshot of the sums and walks the 36 entries row-major into
// the output register, one beat per cycle while the sink takes them.
// ----------------------------------------------------------------------------
module rim_emit #(
  parameter int CNT_W = $clog2(rim_pkg::MAX_POINTS_DEF + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               snap_load_i,
  input  rim_pkg::sums_t                     snap_i,
  input  logic [rim_pkg::MARK_N-1:0]         snap_marks_i,
  input  logic [CNT_W-1:0]                   snap_cnt_i,
  output logic                               busy_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rim_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                               out_sat_o,
  output logic                               out_last_o
);
  import rim_pkg::*;

  sums_t                   snap_q;
  logic [MARK_N-1:0]       marks_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    busy_q;
  logic [2:0]              row_q, col_q;
  logic                    valid_q;
  logic [OUT_DATA_W-1:0]   data_q;
  logic                    sat_q;
  logic                    last_q;
  logic                    load;
  logic signed [ACC_W-1:0] cnt_val;
  entry_t                  ent;

  assign load    = busy_q && (!valid_q || out_ready_i);
  assign cnt_val = ACC_W'(cnt_q) << FRAC_OUT;
  assign ent     = calc_entry(snap_q, marks_q, cnt_val, row_q, col_q);

  always_ff @(posedge clk_i) begin
    if (snap_load_i) begin
      snap_q  <= snap_i;
      marks_q <= snap_marks_i;
      cnt_q   <= snap_cnt_i;
    end
    if (load) begin
      data_q <= {{(OUT_DATA_W-ACC_W-6){1'b0}}, ent.value, col_q, row_q};
      sat_q  <= ent.sat;
      last_q <= (row_q == LAST_IDX) && (col_q == LAST_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (snap_load_i) begin
        busy_q <= 1'b1;
        row_q  <= '0;
        col_q  <= '0;
      end else if (load) begin
        if (col_q == LAST_IDX) begin
          col_q <= '0;
          if (row_q == LAST_IDX) begin
            busy_q <= 1'b0;
          end else begin
            row_q <= row_q + 3'd1;
          end
        end else begin
          col_q <= col_q + 3'd1;
        end
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_sat_o   = sat_q;
  assign out_last_o  = last_q;

endmodule

// ----- rtl/core/registration_information_matrix.sv -----
// ----------------------------------------------------------------------------
// registration_information_matrix: 6x6 information matrix accumulator
// Sums point moments of matched target points and emits the 36 matrix
// entries in Q.24, row-major, at the end of each point set.
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat content
//  ---------+-----+------------------------------------------------------
//  s_axis   | in  | one target point (x, y, z in Q.12), tlast ends the set
//  m_axis   | out | one matrix entry (row, col, Q.24 value), tuser = clamped,
//           |     | tlast on entry (5,5)
//
//  Points are taken one per cycle, back to back, while s_axis_tready is
//  high. A point passes an input register, a product stage (six 24x24
//  multiplies) and the saturating accumulators; the sums of a set then go
//  through the emitter's snapshot and output registers to m_axis.
//  A set end hands a snapshot to the emitter, which sends 36 beats, one per
//  cycle at full m_axis_tready; accumulation of the next set goes on meanwhile.
//  s_axis_tready drops only when a second set end reaches the accumulators
//  while the emitter still holds the previous matrix.
//  Reset (rst_ni low, asynchronous) clears all sums, marks and the count.
//
module registration_information_matrix #(
  parameter int MAX_POINTS = rim_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // point stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [rim_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,   // x_coord, y_coord, z_coord
  input  logic                           s_axis_tlast_i,   // last_point
  // matrix entry stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [rim_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,   // row_index, col_index,
                                                           // entry_value, 2 pad bits
  output logic                           m_axis_tuser_o,   // saturated
  output logic                           m_axis_tlast_o    // last_entry
);
  import rim_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic              emit_busy;
  logic              snap_load;
  sums_t             snap;
  logic [MARK_N-1:0] snap_marks;
  logic [CNT_W-1:0]  snap_cnt;

  rim_accum #(
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .x_i          (s_axis_tdata_i[COORD_W-1:0]),
    .y_i          (s_axis_tdata_i[2*COORD_W-1:COORD_W]),
    .z_i          (s_axis_tdata_i[3*COORD_W-1:2*COORD_W]),
    .last_i       (s_axis_tlast_i),
    .emit_busy_i  (emit_busy),
    .snap_load_o  (snap_load),
    .snap_o       (snap),
    .snap_marks_o (snap_marks),
    .snap_cnt_o   (snap_cnt)
  );

  rim_emit #(
    .CNT_W (CNT_W)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_load_i  (snap_load),
    .snap_i       (snap),
    .snap_marks_i (snap_marks),
    .snap_cnt_i   (snap_cnt),
    .busy_o       (emit_busy),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o),
    .out_sat_o    (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

  // Input only stalls while a matrix is still being drained.
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> emit_busy)
    else $error("input stalled with idle emitter");

  // A snapshot never lands on a matrix that is still being sent.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_load |-> !emit_busy)
    else $error("snapshot overwrote a matrix in flight");

  // tlast marks entry (5,5) only.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o ==
      ((m_axis_tdata_o[2:0] == LAST_IDX) && (m_axis_tdata_o[5:3] == LAST_IDX))))
    else $error("tlast not on the final entry");

endmodule

// ----- tb/rim_matrix_checker.sv -----
// ----------------------------------------------------------------------------
// rim_matrix_checker: scoreboard for the information matrix accumulator
// Watches the point and matrix-entry streams, keeps its own copy of the
// moment sums, works out the 36 entries of every closed set and compares
// each entry beat against the oldest expected one.
// ----------------------------------------------------------------------------
module rim_matrix_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pt_valid_i,
  input  logic                           pt_ready_i,
  input  logic [rim_pkg::IN_DATA_W-1:0]  pt_data_i,    // x_coord, y_coord, z_coord
  input  logic                           pt_last_i,    // last_point
  input  logic                           ent_valid_i,
  input  logic                           ent_ready_i,
  input  logic [rim_pkg::OUT_DATA_W-1:0] ent_data_i,   // row_index, col_index,
                                                       // entry_value, pad
  input  logic                           ent_user_i,   // saturated
  input  logic                           ent_last_i,   // last_entry
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);
  import rim_pkg::*;

  localparam int POINT_CAP  = MAX_POINTS_DEF;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [2:0]              row;
    logic [2:0]              col;
    logic signed [ACC_W-1:0] value;
    logic                    sat;
    logic                    is_last;
  } matrix_entry_t;

  // moment sums: squares xx/yy/zz, cross xy/xz/yz, linear x/y/z
  logic signed [ACC_W-1:0] sq_sum  [3];
  logic signed [ACC_W-1:0] xp_sum  [3];
  logic signed [LIN_W-1:0] lin_sum [3];
  logic [ACC_W-1:0]        npoints;
  logic [MARK_N-1:0]       ovf;

  matrix_entry_t expected_entries[$];
  matrix_entry_t got;
  matrix_entry_t want;
  int            fails = 0;
  int            checked = 0;

  function automatic logic signed [ACC_W-1:0] add64_clamp(input logic signed [ACC_W-1:0] a,
                                                          input logic signed [ACC_W-1:0] b,
                                                          output logic ov);
    logic [ACC_W:0] w;
    w  = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    ov = (w[ACC_W] != w[ACC_W-1]);
    if (ov) return w[ACC_W] ? ACC_MIN : ACC_MAX;
    return w[ACC_W-1:0];
  endfunction

  function automatic logic signed [LIN_W-1:0] add41_clamp(input logic signed [LIN_W-1:0] s,
                                                          input logic signed [ACC_W-1:0] v,
                                                          output logic ov);
    logic signed [ACC_W-1:0] w;
    w  = s;
    w  = w + v;
    ov = 1'b1;
    if (w > LIN_MAX) return LIN_MAX;
    if (w < LIN_MIN) return LIN_MIN;
    ov = 1'b0;
    return w[LIN_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] neg_clamp(input logic signed [ACC_W-1:0] a,
                                                        output logic ov);
    ov = (a == ACC_MIN);
    return ov ? ACC_MAX : -a;
  endfunction

  // Q.12 linear sum widened to Q.24
  function automatic logic signed [ACC_W-1:0] lin_q24(input logic signed [LIN_W-1:0] s);
    logic signed [ACC_W-1:0] w;
    w = s;
    return w <<< LIN_SHIFT;
  endfunction

  function automatic matrix_entry_t matrix_entry(input logic [2:0] r, input logic [2:0] c);
    logic [2:0]    lo;
    logic [2:0]    hi;
    logic          o;
    matrix_entry_t e;
    lo        = (r < c) ? r : c;
    hi        = (r < c) ? c : r;
    o         = 1'b0;
    e.row     = r;
    e.col     = c;
    e.value   = '0;
    e.sat     = 1'b0;
    e.is_last = (r == LAST_IDX) && (c == LAST_IDX);
    case ({lo, hi})
      {3'd0, 3'd0}: begin
        e.value = add64_clamp(sq_sum[1], sq_sum[2], o);
        e.sat   = ovf[OVM_YY] | ovf[OVM_ZZ] | o;
      end
      {3'd1, 3'd1}: begin
        e.value = add64_clamp(sq_sum[0], sq_sum[2], o);
        e.sat   = ovf[OVM_XX] | ovf[OVM_ZZ] | o;
      end
      {3'd2, 3'd2}: begin
        e.value = add64_clamp(sq_sum[0], sq_sum[1], o);
        e.sat   = ovf[OVM_XX] | ovf[OVM_YY] | o;
      end
      {3'd0, 3'd1}: begin
        e.value = neg_clamp(xp_sum[0], o);
        e.sat   = ovf[OVM_XY] | o;
      end
      {3'd0, 3'd2}: begin
        e.value = neg_clamp(xp_sum[1], o);
        e.sat   = ovf[OVM_XZ] | o;
      end
      {3'd1, 3'd2}: begin
        e.value = neg_clamp(xp_sum[2], o);
        e.sat   = ovf[OVM_YZ] | o;
      end
      {3'd0, 3'd4}: begin e.value = -lin_q24(lin_sum[2]); e.sat = ovf[OVM_SZ]; end
      {3'd0, 3'd5}: begin e.value =  lin_q24(lin_sum[1]); e.sat = ovf[OVM_SY]; end
      {3'd1, 3'd3}: begin e.value =  lin_q24(lin_sum[2]); e.sat = ovf[OVM_SZ]; end
      {3'd1, 3'd5}: begin e.value = -lin_q24(lin_sum[0]); e.sat = ovf[OVM_SX]; end
      {3'd2, 3'd3}: begin e.value = -lin_q24(lin_sum[1]); e.sat = ovf[OVM_SY]; end
      {3'd2, 3'd4}: begin e.value =  lin_q24(lin_sum[0]); e.sat = ovf[OVM_SX]; end
      {3'd3, 3'd3}, {3'd4, 3'd4}, {3'd5, 3'd5}: begin
        e.value = npoints << FRAC_OUT;
      end
      default: begin
        e.value = '0;
      end
    endcase
    return e;
  endfunction

  task automatic clear_sums();
    for (int k = 0; k < 3; k++) begin
      sq_sum[k]  = '0;
      xp_sum[k]  = '0;
      lin_sum[k] = '0;
    end
    npoints = '0;
    ovf     = '0;
  endtask

  task automatic accumulate_point(input logic signed [ACC_W-1:0] x,
                                  input logic signed [ACC_W-1:0] y,
                                  input logic signed [ACC_W-1:0] z);
    logic o;
    // points past the cap are dropped, the set end still counts
    if (npoints < POINT_CAP) begin
      npoints    = npoints + 1;
      sq_sum[0]  = add64_clamp(sq_sum[0], x * x, o);  ovf[OVM_XX] |= o;
      sq_sum[1]  = add64_clamp(sq_sum[1], y * y, o);  ovf[OVM_YY] |= o;
      sq_sum[2]  = add64_clamp(sq_sum[2], z * z, o);  ovf[OVM_ZZ] |= o;
      xp_sum[0]  = add64_clamp(xp_sum[0], x * y, o);  ovf[OVM_XY] |= o;
      xp_sum[1]  = add64_clamp(xp_sum[1], x * z, o);  ovf[OVM_XZ] |= o;
      xp_sum[2]  = add64_clamp(xp_sum[2], y * z, o);  ovf[OVM_YZ] |= o;
      lin_sum[0] = add41_clamp(lin_sum[0], x, o);     ovf[OVM_SX] |= o;
      lin_sum[1] = add41_clamp(lin_sum[1], y, o);     ovf[OVM_SY] |= o;
      lin_sum[2] = add41_clamp(lin_sum[2], z, o);     ovf[OVM_SZ] |= o;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_sums();
      expected_entries.delete();
      fails        = 0;
      checked      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // entry side first: an entry beat can never belong to a set closed at this edge
      if (ent_valid_i && ent_ready_i) begin
        got.row     = ent_data_i[2:0];
        got.col     = ent_data_i[5:3];
        got.value   = ent_data_i[6 +: ACC_W];
        got.sat     = ent_user_i;
        got.is_last = ent_last_i;
        if (expected_entries.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("unexpected entry beat: r%0d c%0d v=%h sat=%b last=%b",
                     got.row, got.col, got.value, got.sat, got.is_last);
        end else begin
          want = expected_entries.pop_front();
          checked++;
          if ((got.row !== want.row) || (got.col !== want.col) ||
              (got.value !== want.value) || (got.sat !== want.sat) ||
              (got.is_last !== want.is_last)) begin
            fails++;
            if (fails <= REPORT_MAX)
              $display("entry mismatch: exp r%0d c%0d v=%h sat=%b last=%b | got r%0d c%0d v=%h sat=%b last=%b",
                       want.row, want.col, want.value, want.sat, want.is_last,
                       got.row, got.col, got.value, got.sat, got.is_last);
          end
        end
      end
      if (pt_valid_i && pt_ready_i) begin
        accumulate_point($signed(pt_data_i[0 +: COORD_W]),
                         $signed(pt_data_i[COORD_W +: COORD_W]),
                         $signed(pt_data_i[2*COORD_W +: COORD_W]));
        if (pt_last_i) begin
          for (int r = 0; r < 6; r++)
            for (int c = 0; c < 6; c++)
              expected_entries.push_back(matrix_entry(r[2:0], c[2:0]));
          clear_sums();
        end
      end
      fail_count_o <= fails;
      pending_o    <= expected_entries.size();
      checked_o    <= checked;
    end
  end

endmodule

// ----- tb/registration_information_matrix_tb.sv -----
// ----------------------------------------------------------------------------
// registration_information_matrix_tb: top of the information matrix bench
// Drives point sets into the accumulator under several valid/ready pressure
// phases; a separate checker predicts and compares every matrix entry.
// ----------------------------------------------------------------------------
module registration_information_matrix_tb;
  import rim_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;   // quiet cycles before giving up
  localparam int TAIL_CYCLES    = 16;     // settle time after the last entry
  localparam int PHASE_POINTS   = 110;    // random points per pressure phase
  localparam int MAX_SET_LEN    = 12;

  localparam logic [COORD_W-1:0] C_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] C_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] C_ZERO = '0;
  localparam logic [COORD_W-1:0] C_ONE  = 1;
  localparam logic [COORD_W-1:0] C_NEG1 = '1;
  localparam logic [COORD_W-1:0] C_ALT0 = 24'hAAAAAA;
  localparam logic [COORD_W-1:0] C_ALT1 = 24'h555555;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  // point stream (driven here)
  logic                  pt_valid = 1'b0;
  logic                  pt_ready;
  logic [IN_DATA_W-1:0]  pt_data  = '0;
  logic                  pt_last  = 1'b0;

  // matrix entry stream
  logic                  ent_valid;
  logic                  ent_ready = 1'b0;
  logic [OUT_DATA_W-1:0] ent_data;
  logic                  ent_user;
  logic                  ent_last;

  int fail_count;
  int pending;
  int checked;

  int idle_pct  = 0;    // sender gap chance per cycle, used by the stimulus process only
  int stall_pct = 0;    // receiver stall chance, written with NBA
  int n_points  = 0;
  int n_sets    = 0;
  int quiet     = 0;

  registration_information_matrix u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (pt_valid),
    .s_axis_tready_o (pt_ready),
    .s_axis_tdata_i  (pt_data),
    .s_axis_tlast_i  (pt_last),
    .m_axis_tvalid_o (ent_valid),
    .m_axis_tready_i (ent_ready),
    .m_axis_tdata_o  (ent_data),
    .m_axis_tuser_o  (ent_user),
    .m_axis_tlast_o  (ent_last)
  );

  rim_matrix_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .pt_valid_i   (pt_valid),
    .pt_ready_i   (pt_ready),
    .pt_data_i    (pt_data),
    .pt_last_i    (pt_last),
    .ent_valid_i  (ent_valid),
    .ent_ready_i  (ent_ready),
    .ent_data_i   (ent_data),
    .ent_user_i   (ent_user),
    .ent_last_i   (ent_last),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Receiver: random stalls at the current phase's rate
  always @(posedge clk) begin
    ent_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: counts cycles with no beat on either stream
  always @(posedge clk) begin
    if (rst_n) begin
      if ((pt_valid && pt_ready) || (ent_valid && ent_ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
        if (quiet + 1 >= WATCHDOG_LIMIT) begin
          $display("watchdog: no beat for %0d cycles, %0d entries outstanding",
                   WATCHDOG_LIMIT, pending);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // Mix of extremes, small values near zero and full random patterns
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return COORD_W'($urandom_range(8191)) - COORD_W'(4096);
      default: return COORD_W'($urandom());
    endcase
  endfunction

  // One point beat; a random gap may come first, valid is left high afterwards
  // so back-to-back points never toggle it within a step
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z, input logic is_last);
    while ($urandom_range(99) < idle_pct) begin
      pt_valid <= 1'b0;
      @(posedge clk);
    end
    pt_valid <= 1'b1;
    pt_data  <= {z, y, x};
    pt_last  <= is_last;
    do @(posedge clk); while (!pt_ready);
    n_points++;
    if (is_last) n_sets++;
  endtask

  // Stop sending and wait until every expected entry has come back.
  // The count is tested only after waiting on the clock, so the checker's count reflects the last beat.
  task automatic drain_entries();
    pt_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_sets(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, MAX_SET_LEN);
      for (int i = 0; i < len; i++)
        send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: extremes, bit patterns, one-point set, zero set ----
    send_point(C_MAX, C_MIN, C_ZERO, 1'b1);         // set closed on its first point
    send_point(C_MAX, C_MAX, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, C_ZERO, 1'b0);
    send_point(C_ZERO, C_MIN, C_MAX, 1'b0);
    send_point(C_ONE, C_NEG1, C_ONE, 1'b1);
    send_point(C_ALT0, C_ALT1, C_ALT0, 1'b0);
    send_point(C_ALT1, C_ALT0, C_ALT1, 1'b1);
    send_point(C_ZERO, C_ZERO, C_ZERO, 1'b1);
    send_point(C_NEG1, C_ZERO, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, C_MAX, 1'b1);
    drain_entries();

    // ---- random sets under four pressure phases ----
    idle_pct = 0;   stall_pct <= 0;
    random_sets(PHASE_POINTS);
    drain_entries();
    idle_pct = 77;  stall_pct <= 0;
    random_sets(PHASE_POINTS);
    drain_entries();
    idle_pct = 0;   stall_pct <= 77;
    random_sets(PHASE_POINTS);
    drain_entries();
    idle_pct = 34;  stall_pct <= 34;
    random_sets(PHASE_POINTS);
    drain_entries();

    // late or stray entry beats are caught by the checker meanwhile
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d points in %0d sets, %0d matrix entries compared,",
             n_points, n_sets, checked);
    $display("with directed extreme points and four valid/ready pressure phases");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d entries missing", fail_count, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rim_pkg.sv
rtl/core/rim_accum.sv
rtl/core/rim_emit.sv
rtl/core/registration_information_matrix.sv
tb/rim_matrix_checker.sv
tb/registration_information_matrix_tb.sv
